>>> design/bndt_pkg.sv
// Shared types, constants and the gamma table for the blue-noise dither block.
// No dependencies; imported by every module of the block except bndt_ram.
`timescale 1ns / 1ps

package bndt_pkg;

    localparam int COORD_BITS = 12;
    localparam int TILE_SIDE  = 64;
    localparam int TILE_BITS  = $clog2(TILE_SIDE);
    localparam int TILE_DEPTH = TILE_SIDE * TILE_SIDE;
    localparam int ADDR_BITS  = 2 * TILE_BITS;
    localparam int SIZE_BITS  = 7;
    localparam int COLOR_BITS = 8;
    localparam int THR_BITS   = 9;
    localparam int DATA_BITS  = 9;
    localparam int INDEX_BITS = 3;

    // remainder unit retires two quotient bits per stage
    localparam int MOD_STAGES = (COORD_BITS + 1) / 2;
    localparam int MOD_W      = COORD_BITS + SIZE_BITS;

    // luma weights, 16-bit fraction
    localparam int COEF_BITS  = 16;
    localparam int PROD_BITS  = COLOR_BITS + COEF_BITS;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int LUMA_SHIFT = 16;
    localparam logic [COEF_BITS-1:0] COEF_RED   = 16'd19595;
    localparam logic [COEF_BITS-1:0] COEF_GREEN = 16'd38470;
    localparam logic [COEF_BITS-1:0] COEF_BLUE  = 16'd7471;

    localparam logic [COLOR_BITS-1:0] COLOR_MAX  = '1;
    localparam logic [COLOR_BITS:0]   NOISE_BIAS = 9'd128;

    typedef enum logic [1:0] {
        MODE_LUMA                = 2'd0,
        MODE_NOISE_LUMA          = 2'd1,
        MODE_CHANNEL             = 2'd2,
        MODE_GAMMA_NOISE_CHANNEL = 2'd3
    } mode_t;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_MODE        = 3'd0,
        REG_TILE_WIDTH  = 3'd1,
        REG_TILE_HEIGHT = 3'd2,
        REG_LUMA_THR    = 3'd3,
        REG_RED_THR     = 3'd4,
        REG_GREEN_THR   = 3'd5,
        REG_BLUE_THR    = 3'd6
    } reg_index_t;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_WRITE = 1'b1
    } command_t;

    typedef struct packed {
        logic gamma_on;
        logic noise_on;
    } lane_ctrl_t;

    typedef struct packed {
        logic gam;
        logic nse;
        logic mul;
    } lane_en_t;

    typedef struct packed {
        logic                  is_write;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic [TILE_BITS-1:0]  trow;
        logic [TILE_BITS-1:0]  tcol;
        logic [COLOR_BITS-1:0] tval;
    } item_t;

    typedef logic [COLOR_BITS-1:0] gamma_lut_t [256];

    // floor(255 * (v/255)^1.5): largest t with 255*t*t <= v^3, built bit by bit
    function automatic gamma_lut_t build_gamma_lut();
        gamma_lut_t      lut;
        longint unsigned cube;
        longint unsigned t;
        longint unsigned cand;
        for (int v = 0; v < 256; v++)
        begin
            cube = longint'(v) * longint'(v) * longint'(v);
            t = 0;
            for (int b = 7; b >= 0; b--)
            begin
                cand = t | (longint'(1) << b);
                if (255 * cand * cand <= cube)
                begin
                    t = cand;
                end
            end
            lut[v] = COLOR_BITS'(t);
        end
        return lut;
    endfunction

    localparam gamma_lut_t GAMMA_LUT = build_gamma_lut();

endpackage

>>> design/bndt_ram.sv
// Generic single-write, single-read RAM with registered read and read enable.
// No package dependency.
`timescale 1ns / 1ps

module bndt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/bndt_mod.sv
// Pipelined remainder: coordinate modulo tile size, two restoring steps per stage.
// Depends on bndt_pkg.
`timescale 1ns / 1ps

module bndt_mod (
    input  logic                               clk,
    input  logic [bndt_pkg::MOD_STAGES-1:0]    en,
    input  logic [bndt_pkg::COORD_BITS-1:0]    dividend,
    input  logic [bndt_pkg::SIZE_BITS-1:0]     divisor,
    output logic [bndt_pkg::COORD_BITS-1:0]    remainder
);

    import bndt_pkg::*;

    // one restoring step: subtract divisor << k when it fits
    function automatic logic [COORD_BITS-1:0] sub_step(
        input logic [COORD_BITS-1:0] rem,
        input logic [SIZE_BITS-1:0]  dv,
        input int                    k
    );
        logic [MOD_W-1:0] rw;
        logic [MOD_W-1:0] dw;
        if (k < 0)
        begin
            return rem;
        end
        rw = MOD_W'(rem);
        dw = MOD_W'(dv) << k;
        if (rw >= dw)
        begin
            return COORD_BITS'(rw - dw);
        end
        return rem;
    endfunction

    logic [COORD_BITS-1:0] rem_reg  [MOD_STAGES];
    logic [COORD_BITS-1:0] rem_next [MOD_STAGES];

    for (genvar s = 0; s < MOD_STAGES; s++)
    begin : g_stage
        logic [COORD_BITS-1:0] stage_in;

        if (s == 0)
        begin : g_first
            assign stage_in = dividend;
        end
        else
        begin : g_rest
            assign stage_in = rem_reg[s-1];
        end

        always_comb
        begin
            rem_next[s] = sub_step(sub_step(stage_in, divisor, COORD_BITS - 1 - 2 * s),
                                   divisor, COORD_BITS - 2 - 2 * s);
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s] <= rem_next[s];
            end
        end
    end

    assign remainder = rem_reg[MOD_STAGES-1];

endmodule

>>> design/bndt_lane.sv
// One color lane: gamma, noise offset with clamp, luma weight and channel compare.
// Depends on bndt_pkg.
`timescale 1ns / 1ps

module bndt_lane (
    input  logic                              clk,
    input  bndt_pkg::lane_en_t                en,
    input  bndt_pkg::lane_ctrl_t              ctrl,
    input  logic [bndt_pkg::COLOR_BITS-1:0]   color,
    input  logic [bndt_pkg::COLOR_BITS-1:0]   noise,
    input  logic [bndt_pkg::COEF_BITS-1:0]    coef,
    input  logic [bndt_pkg::THR_BITS-1:0]     threshold,
    output logic [bndt_pkg::PROD_BITS-1:0]    product,
    output logic                              hit
);

    import bndt_pkg::*;

    logic [COLOR_BITS-1:0] gam_reg;
    logic [COLOR_BITS-1:0] gam_next;
    logic [COLOR_BITS-1:0] nse_reg;
    logic [COLOR_BITS-1:0] nse_next;
    logic [COLOR_BITS:0]   sum;
    logic [COLOR_BITS:0]   biased;
    logic [PROD_BITS-1:0]  prod_reg;
    logic                  hit_reg;

    assign gam_next = ctrl.gamma_on ? GAMMA_LUT[color] : color;

    // c + n - 128, clamped to 0..255
    always_comb
    begin
        sum    = {1'b0, gam_reg} + {1'b0, noise};
        biased = sum - NOISE_BIAS;
        if (!ctrl.noise_on)
        begin
            nse_next = gam_reg;
        end
        else if (sum < NOISE_BIAS)
        begin
            nse_next = '0;
        end
        else if (biased[COLOR_BITS])
        begin
            nse_next = COLOR_MAX;
        end
        else
        begin
            nse_next = biased[COLOR_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.gam)
        begin
            gam_reg <= gam_next;
        end
        if (en.nse)
        begin
            nse_reg <= nse_next;
        end
        if (en.mul)
        begin
            prod_reg <= PROD_BITS'(nse_reg * coef);
            hit_reg  <= THR_BITS'(nse_reg) >= threshold;
        end
    end

    assign product = prod_reg;
    assign hit     = hit_reg;

endmodule

>>> design/blue_noise_dither_threshold.sv
// Top level of the blue-noise ordered dither: config registers, pipeline control,
// tile memory, remainder units, three color lanes and the luma merge stage.
// Depends on bndt_pkg, bndt_ram, bndt_mod, bndt_lane.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid / in_stall): one word per pixel or tile write.
//   command = pixel: pos_x, pos_y, red_in, green_in, blue_in are used and
//   one output word follows. command = write: tile_row, tile_col,
//   tile_value store one noise byte; no output word.
// - Output channel (out_valid / out_stall): red_out, green_out, blue_out,
//   each 0 or 255, in input order.
// - Config port: cfg_write, cfg_index, cfg_data; write only while idle.
// - Throughput: one word per clock while out_stall does not hold the pipeline, no bubbles between words.
// - Pipeline: ten register stages (6 remainder stages for the tile
//   coordinates, tile read, noise add, multiply, output register), the
//   first loaded at the accepting edge.
// - Tile writes travel the same pipeline and land at the tile read stage,
//   so pixels always see exactly the writes accepted before them.
// - Out stall: each stage holds while the one after it is full and held;
//   empty stages keep filling, so in_stall rises only once every stage is full.
// - Reset clears the pipeline and loads default registers. The tile is not
//   cleared; pixels that read unwritten entries give undefined results.
module blue_noise_dither_threshold (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [bndt_pkg::INDEX_BITS-1:0]    cfg_index,
    input  logic [bndt_pkg::DATA_BITS-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic [11:0]                        pos_x,
    input  logic [11:0]                        pos_y,
    input  logic [7:0]                         red_in,
    input  logic [7:0]                         green_in,
    input  logic [7:0]                         blue_in,
    input  logic [5:0]                         tile_row,
    input  logic [5:0]                         tile_col,
    input  logic [7:0]                         tile_value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         red_out,
    output logic [7:0]                         green_out,
    output logic [7:0]                         blue_out
);

    import bndt_pkg::*;

    // stage map: 0..MOD_STAGES-1 remainder, then tile read, noise, multiply
    localparam int RAM_STAGE = MOD_STAGES;
    localparam int NSE_STAGE = MOD_STAGES + 1;
    localparam int MUL_STAGE = MOD_STAGES + 2;
    localparam int PIPE      = MOD_STAGES + 3;

    // ---------------- config registers ----------------
    mode_t                mode_reg;
    logic [SIZE_BITS-1:0] tile_width_reg;
    logic [SIZE_BITS-1:0] tile_height_reg;
    logic [THR_BITS-1:0]  luma_thr_reg;
    logic [THR_BITS-1:0]  red_thr_reg;
    logic [THR_BITS-1:0]  green_thr_reg;
    logic [THR_BITS-1:0]  blue_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_NOISE_LUMA;
            tile_width_reg  <= 7'd64;
            tile_height_reg <= 7'd64;
            luma_thr_reg    <= 9'd159;
            red_thr_reg     <= 9'd131;
            green_thr_reg   <= 9'd135;
            blue_thr_reg    <= 9'd129;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:        mode_reg        <= mode_t'(cfg_data[1:0]);
                REG_TILE_WIDTH:  tile_width_reg  <= cfg_data[SIZE_BITS-1:0];
                REG_TILE_HEIGHT: tile_height_reg <= cfg_data[SIZE_BITS-1:0];
                REG_LUMA_THR:    luma_thr_reg    <= cfg_data[THR_BITS-1:0];
                REG_RED_THR:     red_thr_reg     <= cfg_data[THR_BITS-1:0];
                REG_GREEN_THR:   green_thr_reg   <= cfg_data[THR_BITS-1:0];
                REG_BLUE_THR:    blue_thr_reg    <= cfg_data[THR_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // tile size: zero acts as one, above the tile side acts as the side
    function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] s);
        if (s == '0)
        begin
            return SIZE_BITS'(1);
        end
        if (s > SIZE_BITS'(TILE_SIDE))
        begin
            return SIZE_BITS'(TILE_SIDE);
        end
        return s;
    endfunction

    logic [SIZE_BITS-1:0] width_eff;
    logic [SIZE_BITS-1:0] height_eff;
    lane_ctrl_t           lane_ctrl;
    logic                 luma_mode;

    assign width_eff          = clamp_size(tile_width_reg);
    assign height_eff         = clamp_size(tile_height_reg);
    assign lane_ctrl.gamma_on = (mode_reg == MODE_GAMMA_NOISE_CHANNEL);
    assign lane_ctrl.noise_on = (mode_reg == MODE_NOISE_LUMA) ||
                                (mode_reg == MODE_GAMMA_NOISE_CHANNEL);
    assign luma_mode          = (mode_reg == MODE_LUMA) || (mode_reg == MODE_NOISE_LUMA);

    // ---------------- pipeline control ----------------
    // rdy[i]: stage i may load this cycle; rdy[PIPE] is the output register
    logic [PIPE-1:0] v_reg;
    logic [PIPE-1:0] v_next;
    logic [PIPE:0]   rdy;
    logic            out_valid_reg;
    logic            accept;

    assign rdy[PIPE] = !out_valid_reg || !out_stall;
    for (genvar i = 0; i < PIPE; i++)
    begin : g_rdy
        assign rdy[i] = !v_reg[i] || rdy[i+1];
    end

    assign in_stall = !rdy[0];
    assign accept   = in_valid && rdy[0];

    // payload riding beside the remainder stages
    item_t item_reg [MOD_STAGES];
    item_t item_in;

    assign item_in.is_write = (command == CMD_WRITE);
    assign item_in.red      = red_in;
    assign item_in.green    = green_in;
    assign item_in.blue     = blue_in;
    assign item_in.trow     = tile_row[TILE_BITS-1:0];
    assign item_in.tcol     = tile_col[TILE_BITS-1:0];
    assign item_in.tval     = tile_value;

    item_t last_item;
    assign last_item = item_reg[MOD_STAGES-1];

    always_comb
    begin
        v_next[0] = accept;
        for (int i = 1; i < PIPE; i++)
        begin
            v_next[i] = v_reg[i-1];
        end
        // writes retire at the tile stage
        v_next[RAM_STAGE] = v_reg[RAM_STAGE-1] && !last_item.is_write;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < PIPE; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
            if (rdy[PIPE])
            begin
                out_valid_reg <= v_reg[PIPE-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            item_reg[0] <= item_in;
        end
        for (int i = 1; i < MOD_STAGES; i++)
        begin
            if (rdy[i])
            begin
                item_reg[i] <= item_reg[i-1];
            end
        end
    end

    // ---------------- tile coordinates ----------------
    logic [COORD_BITS-1:0] x_rem;
    logic [COORD_BITS-1:0] y_rem;

    bndt_mod u_mod_x (
        .clk       (clk),
        .en        (rdy[MOD_STAGES-1:0]),
        .dividend  (pos_x[COORD_BITS-1:0]),
        .divisor   (width_eff),
        .remainder (x_rem)
    );

    bndt_mod u_mod_y (
        .clk       (clk),
        .en        (rdy[MOD_STAGES-1:0]),
        .dividend  (pos_y[COORD_BITS-1:0]),
        .divisor   (height_eff),
        .remainder (y_rem)
    );

    // ---------------- noise tile ----------------
    logic                  tile_we;
    logic [ADDR_BITS-1:0]  tile_waddr;
    logic [ADDR_BITS-1:0]  tile_raddr;
    logic [COLOR_BITS-1:0] noise;

    assign tile_we    = v_reg[RAM_STAGE-1] && last_item.is_write && rdy[RAM_STAGE];
    assign tile_waddr = {last_item.trow, last_item.tcol};
    assign tile_raddr = {y_rem[TILE_BITS-1:0], x_rem[TILE_BITS-1:0]};

    bndt_ram #(
        .WIDTH (COLOR_BITS),
        .DEPTH (TILE_DEPTH)
    ) u_tile (
        .clk   (clk),
        .we    (tile_we),
        .waddr (tile_waddr),
        .wdata (last_item.tval),
        .re    (rdy[RAM_STAGE]),
        .raddr (tile_raddr),
        .rdata (noise)
    );

    // ---------------- color lanes ----------------
    lane_en_t             lane_en;
    logic [PROD_BITS-1:0] prod_r;
    logic [PROD_BITS-1:0] prod_g;
    logic [PROD_BITS-1:0] prod_b;
    logic                 hit_r;
    logic                 hit_g;
    logic                 hit_b;

    assign lane_en.gam = rdy[RAM_STAGE];
    assign lane_en.nse = rdy[NSE_STAGE];
    assign lane_en.mul = rdy[MUL_STAGE];

    bndt_lane u_lane_r (
        .clk       (clk),
        .en        (lane_en),
        .ctrl      (lane_ctrl),
        .color     (last_item.red),
        .noise     (noise),
        .coef      (COEF_RED),
        .threshold (red_thr_reg),
        .product   (prod_r),
        .hit       (hit_r)
    );

    bndt_lane u_lane_g (
        .clk       (clk),
        .en        (lane_en),
        .ctrl      (lane_ctrl),
        .color     (last_item.green),
        .noise     (noise),
        .coef      (COEF_GREEN),
        .threshold (green_thr_reg),
        .product   (prod_g),
        .hit       (hit_g)
    );

    bndt_lane u_lane_b (
        .clk       (clk),
        .en        (lane_en),
        .ctrl      (lane_ctrl),
        .color     (last_item.blue),
        .noise     (noise),
        .coef      (COEF_BLUE),
        .threshold (blue_thr_reg),
        .product   (prod_b),
        .hit       (hit_b)
    );

    // ---------------- merge: luma sum and output register ----------------
    logic [SUM_BITS-1:0]            luma_sum;
    logic [SUM_BITS-LUMA_SHIFT-1:0] luma;
    logic                           luma_hit;
    logic [COLOR_BITS-1:0]          red_out_reg;
    logic [COLOR_BITS-1:0]          green_out_reg;
    logic [COLOR_BITS-1:0]          blue_out_reg;

    assign luma_sum = SUM_BITS'(prod_r) + SUM_BITS'(prod_g) + SUM_BITS'(prod_b);
    assign luma     = luma_sum[SUM_BITS-1:LUMA_SHIFT];
    assign luma_hit = luma >= (SUM_BITS - LUMA_SHIFT)'(luma_thr_reg);

    always_ff @(posedge clk)
    begin
        if (rdy[PIPE] && v_reg[PIPE-1])
        begin
            if (luma_mode)
            begin
                red_out_reg   <= luma_hit ? COLOR_MAX : '0;
                green_out_reg <= luma_hit ? COLOR_MAX : '0;
                blue_out_reg  <= luma_hit ? COLOR_MAX : '0;
            end
            else
            begin
                red_out_reg   <= hit_r ? COLOR_MAX : '0;
                green_out_reg <= hit_g ? COLOR_MAX : '0;
                blue_out_reg  <= hit_b ? COLOR_MAX : '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_out_reg;
    assign green_out = green_out_reg;
    assign blue_out  = blue_out_reg;

endmodule
